@@ design/sssp_pkg.sv @@
package sssp_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 1024;
  localparam int DEF_WEIGHT_BITS  = 16;

  localparam int VERTEX_BITS  = 6;
  localparam int VCOUNT_BITS  = 7;
  localparam int IN_WEIGHT_BITS = 16;
  localparam int DIST_BITS    = 24;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [VERTEX_BITS-1:0] SOURCE_RESET = 6'd0;

  localparam logic signed [DIST_BITS-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [DIST_BITS-1:0] DIST_MIN = 24'sh800000;

  typedef enum logic {
    REG_VCOUNT = 1'b0,
    REG_SOURCE = 1'b1
  } reg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EDGE_RD  = 7'b0000010,
    S_DIST_RD  = 7'b0000100,
    S_RELAX    = 7'b0001000,
    S_EMIT_RD  = 7'b0010000,
    S_EMIT_LD  = 7'b0100000,
    S_EMIT_NEG = 7'b1000000
  } state_t;

endpackage

@@ design/sssp_ram.sv @@
module sssp_ram
  import sssp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/single_source_shortest_path.sv @@
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   edge_from, edge_to, edge_weight, edge_last
// out_      output     out_valid/out_stall vertex_index, reachable, distance,
//                                          negative_cycle, last
// cfg       APB        psel/penable/pready vertex_count @0x0, source_vertex @0x4
//
// Edges load at one item per cycle while idle; an item with edge_last starts the run.
// A run steps each stored edge through edge read, distance read, and relax and write back,
// over vertex_count passes (clamped to 1..MAX_VERTICES), then reads and emits each vertex.
// in_stall stays high from the cycle after edge_last until the final result is loaded.
// Reset clears control, reached flags and the edge count; memories need no clearing.
// A result held under out_stall stays in the output register; the run waits for it.
module single_source_shortest_path
  import sssp_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [VERTEX_BITS-1:0]        in_edge_from,
  input  logic [VERTEX_BITS-1:0]        in_edge_to,
  input  logic signed [IN_WEIGHT_BITS-1:0] in_edge_weight,
  input  logic                          in_edge_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [VERTEX_BITS-1:0]        out_vertex_index,
  output logic                          out_reachable,
  output logic signed [DIST_BITS-1:0]   out_distance,
  output logic                          out_negative_cycle,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_BITS-1:0]      paddr,
  input  logic [CFG_DATA_BITS-1:0]      pwdata,
  output logic [CFG_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int RV     = 2 ** VIDX_W;
  localparam int NV_W   = $clog2(MAX_VERTICES + 1);
  localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET_W   = $clog2(MAX_EDGES + 1);
  localparam int EW     = 2 * VERTEX_BITS + WEIGHT_BITS;
  localparam int SUM_W  = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  state_t                       state_r, state_nxt;
  logic [VCOUNT_BITS-1:0]       vcount_r;
  logic [VERTEX_BITS-1:0]       source_r;
  logic [ET_W-1:0]              total_r, total_nxt;
  logic [NV_W-1:0]              nv_r, nv_nxt;
  logic [EA_W-1:0]              j_r, j_nxt;
  logic [VIDX_W-1:0]            pass_r, pass_nxt;
  logic [VIDX_W-1:0]            i_r, i_nxt;
  logic                         improved_r, improved_nxt;
  logic [RV-1:0]                reached_r, reached_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [VERTEX_BITS-1:0]       out_index_r, out_index_nxt;
  logic                         out_reach_r, out_reach_nxt;
  logic signed [DIST_BITS-1:0]  out_dist_r, out_dist_nxt;
  logic                         out_neg_r, out_neg_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         in_acc, cfg_wr, slot_free;
  logic [VCOUNT_BITS-1:0]       nv_start;
  logic                         src_ok;

  logic                         e_we, e_re;
  logic [EW-1:0]                e_wdata, e_rdata;
  logic [EA_W-1:0]              e_waddr;
  logic signed [WEIGHT_BITS-1:0] w_in;

  logic                         d_we, da_re, db_re;
  logic [VIDX_W-1:0]            d_waddr, da_raddr, db_raddr;
  logic signed [DIST_BITS-1:0]  d_wdata, da_rdata, db_rdata;

  logic [VERTEX_BITS-1:0]       e_from, e_to;
  logic signed [WEIGHT_BITS-1:0] e_w;
  logic                         edge_ok, better, last_edge, check_pass, last_vertex;
  logic signed [SUM_W-1:0]      sum, dist_v_ext;
  logic signed [DIST_BITS-1:0]  sum_sat;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign pready    = 1'b1;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_VCOUNT: prdata = CFG_DATA_BITS'(vcount_r);
      REG_SOURCE: prdata = CFG_DATA_BITS'(source_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
      source_r <= SOURCE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_VCOUNT: vcount_r <= pwdata[VCOUNT_BITS-1:0];
        REG_SOURCE: source_r <= pwdata[VERTEX_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (vcount_r == '0) begin
      nv_start = VCOUNT_BITS'(1);
    end else if (vcount_r > VCOUNT_BITS'(MAX_VERTICES)) begin
      nv_start = VCOUNT_BITS'(MAX_VERTICES);
    end else begin
      nv_start = vcount_r;
    end
  end
  assign src_ok = VCOUNT_BITS'(source_r) < nv_start;

  assign w_in    = WEIGHT_BITS'(in_edge_weight);
  assign e_we    = in_acc && (total_r < ET_W'(MAX_EDGES));
  assign e_waddr = total_r[EA_W-1:0];
  assign e_wdata = {in_edge_from, in_edge_to, w_in};
  assign e_re    = (state_r == S_EDGE_RD);

  sssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (j_r),
    .rdata (e_rdata)
  );

  assign e_from = e_rdata[EW-1 -: VERTEX_BITS];
  assign e_to   = e_rdata[WEIGHT_BITS +: VERTEX_BITS];
  assign e_w    = e_rdata[WEIGHT_BITS-1:0];

  assign da_re    = (state_r == S_DIST_RD) || (state_r == S_EMIT_RD);
  assign db_re    = (state_r == S_DIST_RD);
  assign da_raddr = (state_r == S_EMIT_RD) ? i_r : e_from[VIDX_W-1:0];
  assign db_raddr = e_to[VIDX_W-1:0];

  sssp_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES)) u_dist_ram_a (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (da_re),
    .raddr (da_raddr),
    .rdata (da_rdata)
  );

  sssp_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES)) u_dist_ram_b (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (db_re),
    .raddr (db_raddr),
    .rdata (db_rdata)
  );

  assign edge_ok = (VCOUNT_BITS'(e_from) < VCOUNT_BITS'(nv_r))
                && (VCOUNT_BITS'(e_to) < VCOUNT_BITS'(nv_r))
                && reached_r[e_from[VIDX_W-1:0]];
  assign sum        = SUM_W'(da_rdata) + SUM_W'(e_w);
  assign dist_v_ext = SUM_W'(db_rdata);
  assign better     = !reached_r[e_to[VIDX_W-1:0]] || (sum < dist_v_ext);

  always_comb begin
    if (sum > SUM_W'(DIST_MAX)) begin
      sum_sat = DIST_MAX;
    end else if (sum < SUM_W'(DIST_MIN)) begin
      sum_sat = DIST_MIN;
    end else begin
      sum_sat = sum[DIST_BITS-1:0];
    end
  end

  assign last_edge   = (ET_W'(j_r) + ET_W'(1)) == total_r;
  assign check_pass  = (NV_W'(pass_r) + NV_W'(1)) == nv_r;
  assign last_vertex = (NV_W'(i_r) + NV_W'(1)) == nv_r;

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    nv_nxt        = nv_r;
    j_nxt         = j_r;
    pass_nxt      = pass_r;
    i_nxt         = i_r;
    improved_nxt  = improved_r;
    reached_nxt   = reached_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_index_nxt = out_index_r;
    out_reach_nxt = out_reach_r;
    out_dist_nxt  = out_dist_r;
    out_neg_nxt   = out_neg_r;
    out_last_nxt  = out_last_r;
    d_we          = 1'b0;
    d_waddr       = e_to[VIDX_W-1:0];
    d_wdata       = sum_sat;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (e_we) begin
            total_nxt = total_r + ET_W'(1);
          end
          if (in_edge_last) begin
            nv_nxt       = NV_W'(nv_start);
            j_nxt        = '0;
            pass_nxt     = '0;
            improved_nxt = 1'b0;
            reached_nxt  = '0;
            if (src_ok) begin
              reached_nxt[source_r[VIDX_W-1:0]] = 1'b1;
              d_we    = 1'b1;
              d_waddr = source_r[VIDX_W-1:0];
              d_wdata = '0;
            end
            state_nxt = S_EDGE_RD;
          end
        end
      end
      S_EDGE_RD: state_nxt = S_DIST_RD;
      S_DIST_RD: state_nxt = S_RELAX;
      S_RELAX: begin
        if (edge_ok && better) begin
          if (check_pass) begin
            improved_nxt = 1'b1;
          end else begin
            reached_nxt[e_to[VIDX_W-1:0]] = 1'b1;
            d_we = 1'b1;
          end
        end
        if (last_edge) begin
          j_nxt = '0;
          if (check_pass) begin
            total_nxt = '0;
            i_nxt     = '0;
            state_nxt = (improved_r || (edge_ok && better)) ? S_EMIT_NEG : S_EMIT_RD;
          end else begin
            pass_nxt  = pass_r + VIDX_W'(1);
            state_nxt = S_EDGE_RD;
          end
        end else begin
          j_nxt     = j_r + EA_W'(1);
          state_nxt = S_EDGE_RD;
        end
      end
      S_EMIT_RD: state_nxt = S_EMIT_LD;
      S_EMIT_LD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = VERTEX_BITS'(i_r);
          out_reach_nxt = reached_r[i_r];
          out_dist_nxt  = reached_r[i_r] ? da_rdata : '0;
          out_neg_nxt   = 1'b0;
          out_last_nxt  = last_vertex;
          if (last_vertex) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + VIDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_EMIT_NEG: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = '0;
          out_reach_nxt = 1'b0;
          out_dist_nxt  = '0;
          out_neg_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      reached_r   <= '0;
      out_valid_r <= 1'b0;
      improved_r  <= 1'b0;
      nv_r        <= '0;
      j_r         <= '0;
      pass_r      <= '0;
      i_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      reached_r   <= reached_nxt;
      out_valid_r <= out_valid_nxt;
      improved_r  <= improved_nxt;
      nv_r        <= nv_nxt;
      j_r         <= j_nxt;
      pass_r      <= pass_nxt;
      i_r         <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_index_r <= out_index_nxt;
    out_reach_r <= out_reach_nxt;
    out_dist_r  <= out_dist_nxt;
    out_neg_r   <= out_neg_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_vertex_index   = out_index_r;
  assign out_reachable      = out_reach_r;
  assign out_distance       = out_dist_r;
  assign out_negative_cycle = out_neg_r;
  assign out_last           = out_last_r;

endmodule

@@ design/sssp_checker.sv @@
module sssp_checker
  import sssp_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_edge_last,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [VERTEX_BITS-1:0]      out_vertex_index,
  input logic                        out_reachable,
  input logic signed [DIST_BITS-1:0] out_distance,
  input logic                        out_negative_cycle,
  input logic                        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex_index)
      && $stable(out_distance) && $stable(out_last))
    else $error("stalled output item changed");

  a_neg_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_negative_cycle |-> out_last && !out_reachable
      && out_vertex_index == '0 && out_distance == '0)
    else $error("cycle report malformed");

  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reachable |-> out_distance == '0)
    else $error("unreachable vertex with nonzero distance");

  a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_edge_last |=> in_stall)
    else $error("input not stalled after run start");

endmodule

bind single_source_shortest_path sssp_checker u_sssp_checker (.*);
